/* sv/nbsm_pkg.sv */
package nbsm_pkg;

    // Image store size, default for the top level parameter
    localparam int IMAGE_BYTES_DEF = 1048576;

    // Field widths
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int IPOS_W  = 20;
    localparam int CIDX_W  = 8;
    localparam int CDAT_W  = 16;
    localparam int PAGE_W  = 12;   // 4 KiB windows
    localparam int BANKS   = 8;
    localparam int BANK_W  = 3;

    // Word kinds
    localparam logic OP_BUS  = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Decode constants
    localparam logic [ADDR_W-1:0] VEC_LO        = 16'hFFFC;
    localparam logic [ADDR_W-1:0] VEC_HI        = 16'hFFFD;
    localparam logic [ADDR_W-1:0] BANK_REG_BASE = 16'h5FF8;
    localparam logic [DATA_W-1:0] FILL_BYTE     = 8'hFF;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_BANKING_ENABLE    = 8'd0;
    localparam logic [CIDX_W-1:0] REG_FLAT_BASE         = 8'd1;
    localparam logic [CIDX_W-1:0] REG_FAKE_RESET_ENABLE = 8'd2;
    localparam logic [CIDX_W-1:0] REG_FAKE_RESET_VECTOR = 8'd3;

    localparam logic [ADDR_W-1:0] FLAT_BASE_RST = 16'h8000;

    typedef logic [BANKS-1:0][DATA_W-1:0] bank_file_t;

    // Per-word decode result
    typedef struct packed {
        logic              drive;     // block drives the data bus
        logic              from_ram;  // byte comes from the image store
        logic [DATA_W-1:0] rd_byte;   // byte when not from the store
        logic              ram_we;    // image load
        logic              bank_we;   // bank register write
        logic [BANK_W-1:0] bank_idx;
    } dec_t;

endpackage

/* sv/nbsm_if.sv */
interface nbsm_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic                          chip_select;
    logic                          read_not_write;
    logic [nbsm_pkg::ADDR_W-1:0]   cpu_address;
    logic [nbsm_pkg::DATA_W-1:0]   write_byte;
    logic [nbsm_pkg::IPOS_W-1:0]   image_address;

    modport source (
        output valid, opcode, chip_select, read_not_write, cpu_address,
               write_byte, image_address,
        input  ready
    );
    modport sink (
        input  valid, opcode, chip_select, read_not_write, cpu_address,
               write_byte, image_address,
        output ready
    );
endinterface

interface nbsm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [nbsm_pkg::DATA_W-1:0]   read_byte;
    logic                          drives_bus;

    modport source (output valid, read_byte, drives_bus, input ready);
    modport sink   (input valid, read_byte, drives_bus, output ready);
endinterface

interface nbsm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [nbsm_pkg::CIDX_W-1:0]   index;
    logic [nbsm_pkg::CDAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/nsf_bank_switch_rom_mapper.sv */
// Channel  Dir  Payload                                              Moves when
// req      in   opcode, chip_select, read_not_write, cpu_address,    valid & ready
//               write_byte, image_address
// rsp      out  read_byte, drives_bus                                valid & ready
// cfg      in   index, data                                          valid & ready
//
// One word in per cycle while req.ready is high, one result word per input word,
// registered in stage 1 (decode + image store read), then in the output register.
// After reset the image store is swept to 0xFF, one byte per cycle, with req.ready
// low until the sweep ends. cfg is always ready, also during the sweep.
// The stage holding the store read data accepts a new word while the output
// register waits on rsp.ready; req stalls only when both are full or during the sweep.
module nsf_bank_switch_rom_mapper #(
    parameter int IMAGE_BYTES = nbsm_pkg::IMAGE_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    nbsm_req_if.sink         req,
    nbsm_rsp_if.source       rsp,
    nbsm_cfg_if.sink         cfg
);

    localparam int IDX_W = $clog2(IMAGE_BYTES);

    // configuration registers
    logic                            banking_enable_reg;
    logic [nbsm_pkg::ADDR_W-1:0]     flat_base_reg;
    logic                            fake_reset_enable_reg;
    logic [nbsm_pkg::ADDR_W-1:0]     fake_reset_vector_reg;

    // bank registers, written by bus words
    nbsm_pkg::bank_file_t            bank_reg;

    nbsm_pkg::dec_t                  dec;
    logic [IDX_W-1:0]                rd_addr;
    logic [IDX_W-1:0]                wr_addr;
    logic [nbsm_pkg::DATA_W-1:0]     ram_q;
    logic                            ram_busy;

    // stage 1: decoded word alongside the store read data
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic                            s1_drive_reg;
    logic                            s1_from_ram_reg;
    logic [nbsm_pkg::DATA_W-1:0]     s1_byte_reg;

    // stage 2: result register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_drive_reg;
    logic [nbsm_pkg::DATA_W-1:0]     out_byte_reg;

    logic                            accept;
    logic                            s2_free;
    logic                            s1_adv;

    assign s2_free        = !out_valid_reg || rsp.ready;
    assign s1_adv         = s1_valid_reg && s2_free;
    assign req.ready      = !ram_busy && (!s1_valid_reg || s1_adv);
    assign accept         = req.valid && req.ready;
    assign s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && !rsp.ready);

    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_byte  = out_byte_reg;
    assign rsp.drives_bus = out_drive_reg;

    nbsm_decode #(
        .IMAGE_BYTES (IMAGE_BYTES)
    ) u_decode (
        .opcode            (req.opcode),
        .chip_select       (req.chip_select),
        .read_not_write    (req.read_not_write),
        .cpu_address       (req.cpu_address),
        .image_address     (req.image_address),
        .banking_enable    (banking_enable_reg),
        .flat_base         (flat_base_reg),
        .fake_reset_enable (fake_reset_enable_reg),
        .fake_reset_vector (fake_reset_vector_reg),
        .banks             (bank_reg),
        .dec               (dec),
        .rd_addr           (rd_addr),
        .wr_addr           (wr_addr)
    );

    // store read happens on every accepted word; data holds while stage 1 waits
    nbsm_image_ram #(
        .IMAGE_BYTES (IMAGE_BYTES)
    ) u_image_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (accept && dec.ram_we),
        .wr_addr (wr_addr),
        .wr_data (req.write_byte),
        .re      (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_q),
        .busy    (ram_busy)
    );

    // user writes config only while idle (not enforced); no ordering against words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            banking_enable_reg    <= 1'b0;
            flat_base_reg         <= nbsm_pkg::FLAT_BASE_RST;
            fake_reset_enable_reg <= 1'b0;
            fake_reset_vector_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                nbsm_pkg::REG_BANKING_ENABLE:    banking_enable_reg    <= cfg.data[0];
                nbsm_pkg::REG_FLAT_BASE:         flat_base_reg         <= cfg.data;
                nbsm_pkg::REG_FAKE_RESET_ENABLE: fake_reset_enable_reg <= cfg.data[0];
                nbsm_pkg::REG_FAKE_RESET_VECTOR: fake_reset_vector_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // bank write takes effect at the accept edge, so the next word sees it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= '0;
        end
        else if (accept && dec.bank_we)
        begin
            bank_reg[dec.bank_idx] <= req.write_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_drive_reg    <= dec.drive;
            s1_from_ram_reg <= dec.from_ram;
            s1_byte_reg     <= dec.rd_byte;
        end
    end

    // non-driving words carry a zero byte out of decode
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_drive_reg <= s1_drive_reg;
            out_byte_reg  <= s1_from_ram_reg ? ram_q : s1_byte_reg;
        end
    end

endmodule

/* sv/nbsm_decode.sv */
module nbsm_decode #(
    parameter int IMAGE_BYTES = nbsm_pkg::IMAGE_BYTES_DEF
) (
    input  logic                              opcode,
    input  logic                              chip_select,
    input  logic                              read_not_write,
    input  logic [nbsm_pkg::ADDR_W-1:0]       cpu_address,
    input  logic [nbsm_pkg::IPOS_W-1:0]       image_address,
    input  logic                              banking_enable,
    input  logic [nbsm_pkg::ADDR_W-1:0]       flat_base,
    input  logic                              fake_reset_enable,
    input  logic [nbsm_pkg::ADDR_W-1:0]       fake_reset_vector,
    input  nbsm_pkg::bank_file_t              banks,
    output nbsm_pkg::dec_t                    dec,
    output logic [$clog2(IMAGE_BYTES)-1:0]    rd_addr,
    output logic [$clog2(IMAGE_BYTES)-1:0]    wr_addr
);

    localparam int IDX_W = $clog2(IMAGE_BYTES);
    localparam logic [nbsm_pkg::IPOS_W:0] IMG_LIMIT = (nbsm_pkg::IPOS_W+1)'(IMAGE_BYTES);

    logic                              is_bank_reg;
    logic [nbsm_pkg::BANK_W-1:0]       sel_idx;
    logic [nbsm_pkg::DATA_W-1:0]       sel_bank;
    logic [nbsm_pkg::ADDR_W-1:0]       flat_off;
    logic [nbsm_pkg::IPOS_W-1:0]       pos;
    logic                              pos_ok;
    logic                              load_ok;

    assign is_bank_reg = (cpu_address[nbsm_pkg::ADDR_W-1:nbsm_pkg::BANK_W]
                          == nbsm_pkg::BANK_REG_BASE[nbsm_pkg::ADDR_W-1:nbsm_pkg::BANK_W]);
    // one bank read port: register access or window lookup, never both
    assign sel_idx  = is_bank_reg ? cpu_address[nbsm_pkg::BANK_W-1:0]
                                  : cpu_address[nbsm_pkg::PAGE_W +: nbsm_pkg::BANK_W];
    assign sel_bank = banks[sel_idx];
    assign flat_off = cpu_address - flat_base;
    assign pos      = banking_enable
                    ? {sel_bank, cpu_address[nbsm_pkg::PAGE_W-1:0]}
                    : {{(nbsm_pkg::IPOS_W-nbsm_pkg::ADDR_W){1'b0}}, flat_off};
    assign pos_ok   = ({1'b0, pos} < IMG_LIMIT);
    assign load_ok  = ({1'b0, image_address} < IMG_LIMIT);
    assign rd_addr  = pos[IDX_W-1:0];
    assign wr_addr  = image_address[IDX_W-1:0];

    always_comb
    begin
        dec          = '0;
        dec.bank_idx = cpu_address[nbsm_pkg::BANK_W-1:0];
        if (opcode == nbsm_pkg::OP_LOAD)
        begin
            dec.ram_we = load_ok;
        end
        else if (chip_select)
        begin
            if (fake_reset_enable && read_not_write && cpu_address == nbsm_pkg::VEC_LO)
            begin
                dec.drive   = 1'b1;
                dec.rd_byte = fake_reset_vector[7:0];
            end
            else if (fake_reset_enable && read_not_write
                     && cpu_address == nbsm_pkg::VEC_HI)
            begin
                dec.drive   = 1'b1;
                dec.rd_byte = fake_reset_vector[15:8];
            end
            else if (banking_enable)
            begin
                if (is_bank_reg)
                begin
                    if (read_not_write)
                    begin
                        dec.drive   = 1'b1;
                        dec.rd_byte = sel_bank;
                    end
                    else
                    begin
                        dec.bank_we = 1'b1;
                    end
                end
                else if (cpu_address[nbsm_pkg::ADDR_W-1] && read_not_write)
                begin
                    dec.drive    = 1'b1;
                    dec.from_ram = pos_ok;
                    dec.rd_byte  = pos_ok ? '0 : nbsm_pkg::FILL_BYTE;
                end
            end
            else if (cpu_address >= flat_base && read_not_write)
            begin
                dec.drive    = 1'b1;
                dec.from_ram = pos_ok;
                dec.rd_byte  = pos_ok ? '0 : nbsm_pkg::FILL_BYTE;
            end
        end
    end

endmodule

/* sv/nbsm_image_ram.sv */
module nbsm_image_ram #(
    parameter int IMAGE_BYTES = nbsm_pkg::IMAGE_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              we,
    input  logic [$clog2(IMAGE_BYTES)-1:0]    wr_addr,
    input  logic [nbsm_pkg::DATA_W-1:0]       wr_data,
    input  logic                              re,
    input  logic [$clog2(IMAGE_BYTES)-1:0]    rd_addr,
    output logic [nbsm_pkg::DATA_W-1:0]       rd_data,
    output logic                              busy
);

    localparam int IDX_W = $clog2(IMAGE_BYTES);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(IMAGE_BYTES - 1);

    logic [nbsm_pkg::DATA_W-1:0] mem [IMAGE_BYTES];
    logic [IDX_W-1:0]            clr_cnt_reg;
    logic                        clr_busy_reg;
    logic [nbsm_pkg::DATA_W-1:0] rd_data_reg;
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_addr;
    logic [nbsm_pkg::DATA_W-1:0] mem_data;

    // clearing sweep owns the write port after reset
    assign mem_we   = clr_busy_reg | we;
    assign mem_addr = clr_busy_reg ? clr_cnt_reg : wr_addr;
    assign mem_data = clr_busy_reg ? nbsm_pkg::FILL_BYTE : wr_data;
    assign rd_data  = rd_data_reg;
    assign busy     = clr_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule
